// ----- rtl/bam_pkg.sv -----
package bam_pkg;

   // Sizes of the array.
   localparam int INPUT_NEURONS  = 256;
   localparam int OUTPUT_NEURONS = 256;
   localparam int BINS           = 16;
   localparam int SLICES         = 4;

   // Field widths.
   localparam int REQ_W    = 2;
   localparam int ROW_IN_W = 8;
   localparam int WIDX_W   = 2;
   localparam int WORD_W   = 64;
   localparam int TIME_W   = 16;
   localparam int BIDX_W   = 4;
   localparam int CFG_W    = 12;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(100);

   // Derived widths.
   localparam int SLICE_W = $clog2(SLICES);
   localparam int CNT_W   = SLICE_W + 1;
   localparam int ROW_W   = (INPUT_NEURONS > 1) ? $clog2(INPUT_NEURONS) : 1;
   localparam int BIN_W   = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int STEP_W  = (BIN_W > 1) ? $clog2(BIN_W) : 1;
   localparam int DIV_W   = CFG_W + BIN_W;
   localparam int CMP_W   = (TIME_W > DIV_W) ? TIME_W : DIV_W;
   localparam int SYN_AW  = ROW_W + SLICE_W;
   localparam int MASK_AW = BIN_W + SLICE_W;
   localparam int MASK_DEPTH = 2 ** MASK_AW;

   // Command queue between front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   // Request codes on the input channel.
   localparam logic [REQ_W-1:0] REQ_WRITE = REQ_W'(0);
   localparam logic [REQ_W-1:0] REQ_SPIKE = REQ_W'(1);
   localparam logic [REQ_W-1:0] REQ_READ  = REQ_W'(2);

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_SPIKE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ROW_W-1:0]    row;
      logic [WIDX_W-1:0]   widx;
      logic [WORD_W-1:0]   word;
      logic [BIN_W-1:0]    bin;
      logic                present;
      logic [TIME_W-1:0]   start;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Output neurons that exist in a given slice.
   function automatic logic [WORD_W-1:0] live_bits(input logic [SLICE_W-1:0] slice);
      int                lo;
      int                n;
      logic [WORD_W-1:0] m;
      lo = int'(slice) * WORD_W;
      m  = '0;
      if (lo < OUTPUT_NEURONS) begin
         n = OUTPUT_NEURONS - lo;
         if (n >= WORD_W) begin
            m = ALL_ONES;
         end else begin
            m = (WORD_W'(1) << n) - WORD_W'(1);
         end
      end
      return m;
   endfunction

endpackage

// ----- rtl/binary_assoc_memory_spike_recall_core.sv -----
// Channel   Direction  Handshake              Beat contents
// req_      in         req_valid / req_stall  type, row, word index, matrix word, time, bin
// rsp_      out        rsp_valid / rsp_stall  bin start time, slice index, fired mask, last
// csr_      in         csr_wr_en              bin width (12 bits), no read-back
//
// A spike is taken and then holds req_stall high while the front divides its time stamp
// by the bin width one quotient bit a cycle (four bits for sixteen bins); the back then
// does the read-modify-write of the four mask words of that bin, and the next spike is
// only taken once the front has pushed the last one into the queue.
// Matrix writes pass through both parts at one a cycle while the command queue has room.
// A readout holds the back until its four beats are out; they leave through the output
// register one a cycle unless rsp_stall is high.
// Reset is synchronous; it clears the control state and marks every bin mask as all ones.
// A two-entry command queue lets the front keep accepting while the back waits on rsp_stall.
module binary_assoc_memory_spike_recall_core (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bam_pkg::REQ_W-1:0]     req_type,
   input  logic [bam_pkg::ROW_IN_W-1:0]  req_neuron_row,
   input  logic [bam_pkg::WIDX_W-1:0]    req_word_index,
   input  logic [bam_pkg::WORD_W-1:0]    req_matrix_word,
   input  logic [bam_pkg::TIME_W-1:0]    req_spike_time,
   input  logic [bam_pkg::BIDX_W-1:0]    req_bin_index,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bam_pkg::TIME_W-1:0]    rsp_bin_start_time,
   output logic [bam_pkg::SLICE_W-1:0]   rsp_slice_index,
   output logic [bam_pkg::WORD_W-1:0]    rsp_fired_mask,
   output logic                          rsp_last,

   input  logic                          csr_wr_en,
   input  logic [bam_pkg::CFG_W-1:0]     csr_wr_data
);

   // Time bin width; the user must write it only while the block is quiet (not enforced).
   logic [bam_pkg::CFG_W-1:0] interval_ff, interval_in;

   logic                      q_push;
   logic                      q_pop;
   bam_pkg::cmd_type          q_push_data;
   bam_pkg::cmd_type          q_head;
   bam_pkg::q_status_type     q_stat;

   assign interval_in = csr_wr_en ? csr_wr_data : interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= bam_pkg::CFG_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   // The front checks each beat, works out the bin of a spike and drops beats that have no
   // effect (rows out of range, late or zero-interval spikes, unused request codes).
   bam_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_neuron_row  (req_neuron_row),
      .req_word_index  (req_word_index),
      .req_matrix_word (req_matrix_word),
      .req_spike_time  (req_spike_time),
      .req_bin_index   (req_bin_index),
      .interval        (interval_ff),
      .q_stat          (q_stat),
      .push            (q_push),
      .push_data       (q_push_data)
   );

   bam_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_stat)
   );

   // The back owns the synapse and mask memories and the output register.
   bam_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (q_head),
      .q_stat             (q_stat),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bin_start_time (rsp_bin_start_time),
      .rsp_slice_index    (rsp_slice_index),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_last           (rsp_last)
   );

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("command pushed into a full queue");

   // Once a readout beat is taken, the next slice follows on the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid &&
      (rsp_slice_index == bam_pkg::SLICE_W'($past(rsp_slice_index) + bam_pkg::SLICE_W'(1))))
      else $error("readout beats not consecutive");

   // The last flag marks exactly the final slice.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_slice_index == bam_pkg::SLICE_W'(bam_pkg::SLICES - 1))))
      else $error("last flag does not match slice index");

endmodule

// ----- rtl/bam_ram.sv -----
module bam_ram #(
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bam_front.sv -----
module bam_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bam_pkg::REQ_W-1:0]     req_type,
   input  logic [bam_pkg::ROW_IN_W-1:0]  req_neuron_row,
   input  logic [bam_pkg::WIDX_W-1:0]    req_word_index,
   input  logic [bam_pkg::WORD_W-1:0]    req_matrix_word,
   input  logic [bam_pkg::TIME_W-1:0]    req_spike_time,
   input  logic [bam_pkg::BIDX_W-1:0]    req_bin_index,
   input  logic [bam_pkg::CFG_W-1:0]     interval,
   input  bam_pkg::q_status_type         q_stat,
   output logic                          push,
   output bam_pkg::cmd_type              push_data
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } state_type;

   state_type                        state_ff, state_in;
   bam_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [bam_pkg::TIME_W-1:0]       rem_ff, rem_in;
   logic [bam_pkg::DIV_W-1:0]        div_ff, div_in;
   logic [bam_pkg::BIN_W-1:0]        q_ff, q_in;
   logic [bam_pkg::STEP_W-1:0]       step_ff, step_in;

   logic                             accept;
   logic                             ge;
   logic [bam_pkg::BIN_W-1:0]        q_next;
   logic                             row_ok;
   logic                             time_fits;
   logic [bam_pkg::DIV_W-1:0]        div_full;

   // Restoring division, one quotient bit a cycle; the quotient is known to fit in BIN_W bits.
   assign ge       = bam_pkg::CMP_W'(rem_ff) >= bam_pkg::CMP_W'(div_ff);
   assign q_next   = bam_pkg::BIN_W'({q_ff, ge});
   assign div_full = bam_pkg::DIV_W'(interval) << bam_pkg::BIN_W;
   assign time_fits = bam_pkg::CMP_W'(req_spike_time) < bam_pkg::CMP_W'(div_full);
   assign row_ok   = int'(req_neuron_row) < bam_pkg::INPUT_NEURONS;

   assign push      = (state_ff == F_PUSH) && !q_stat.full;
   assign req_stall = !((state_ff == F_IDLE) || push);
   assign accept    = req_valid && !req_stall;
   assign push_data = cmd_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      step_in  = step_ff;

      unique case (state_ff)
         F_IDLE: begin
         end
         F_DIV: begin
            if (ge) begin
               rem_in = rem_ff - bam_pkg::TIME_W'(div_ff);
            end
            q_in    = q_next;
            div_in  = div_ff >> 1;
            step_in = step_ff - bam_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               cmd_in.bin = q_next;
               state_in   = (int'(q_next) < bam_pkg::BINS) ? F_PUSH : F_IDLE;
            end
         end
         F_PUSH: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (accept) begin
         cmd_in.row     = bam_pkg::ROW_W'(req_neuron_row);
         cmd_in.widx    = req_word_index;
         cmd_in.word    = req_matrix_word;
         cmd_in.bin     = bam_pkg::BIN_W'(req_bin_index);
         cmd_in.present = int'(req_bin_index) < bam_pkg::BINS;
         cmd_in.start   = bam_pkg::TIME_W'(req_bin_index) * bam_pkg::TIME_W'(interval);
         cmd_in.op      = bam_pkg::OP_READ;
         unique case (req_type)
            bam_pkg::REQ_WRITE: begin
               cmd_in.op = bam_pkg::OP_WRITE;
               state_in  = row_ok ? F_PUSH : F_IDLE;
            end
            bam_pkg::REQ_SPIKE: begin
               cmd_in.op = bam_pkg::OP_SPIKE;
               rem_in    = req_spike_time;
               div_in    = bam_pkg::DIV_W'(interval) << (bam_pkg::BIN_W - 1);
               q_in      = '0;
               step_in   = bam_pkg::STEP_W'(bam_pkg::BIN_W - 1);
               state_in  = (row_ok && (interval != '0) && time_fits) ? F_DIV : F_IDLE;
            end
            bam_pkg::REQ_READ: begin
               cmd_in.op = bam_pkg::OP_READ;
               state_in  = F_PUSH;
            end
            default: begin
               state_in = F_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/bam_fifo.sv -----
module bam_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bam_pkg::cmd_type      push_data,
   input  logic                  pop,
   output bam_pkg::cmd_type      head,
   output bam_pkg::q_status_type status
);

   bam_pkg::cmd_type              entries_ff [bam_pkg::Q_DEPTH];
   logic [bam_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bam_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bam_pkg::Q_CNT_W-1:0]   count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == bam_pkg::Q_CNT_W'(bam_pkg::Q_DEPTH);
   assign status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bam_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bam_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bam_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bam_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/bam_back.sv -----
module bam_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bam_pkg::cmd_type              head,
   input  bam_pkg::q_status_type         q_stat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bam_pkg::TIME_W-1:0]    rsp_bin_start_time,
   output logic [bam_pkg::SLICE_W-1:0]   rsp_slice_index,
   output logic [bam_pkg::WORD_W-1:0]    rsp_fired_mask,
   output logic                          rsp_last
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_SPIKE,
      B_OUT
   } state_type;

   state_type                           state_ff, state_in;
   bam_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [bam_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [bam_pkg::MASK_DEPTH-1:0]      valid_ff, valid_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bam_pkg::TIME_W-1:0]          start_ff, start_in;
   logic [bam_pkg::SLICE_W-1:0]         slice_ff, slice_in;
   logic [bam_pkg::WORD_W-1:0]          mask_ff, mask_in;
   logic                                last_ff, last_in;

   logic                                syn_we, syn_re;
   logic [bam_pkg::SYN_AW-1:0]          syn_waddr, syn_raddr;
   logic [bam_pkg::WORD_W-1:0]          syn_rd;
   logic                                mask_we, mask_re;
   logic [bam_pkg::MASK_AW-1:0]         mask_waddr, mask_raddr, out_addr;
   logic [bam_pkg::WORD_W-1:0]          mask_wdata, mask_rd;

   logic [bam_pkg::SLICE_W-1:0]         wr_slice, cur_slice;
   logic [bam_pkg::WORD_W-1:0]          wr_cur, out_cur;
   logic                                slot_free;

   bam_ram #(
      .WIDTH  (bam_pkg::WORD_W),
      .ADDR_W (bam_pkg::SYN_AW)
   ) u_syn_ram (
      .clock   (clock),
      .wr_en   (syn_we),
      .wr_addr (syn_waddr),
      .wr_data (head.word),
      .rd_en   (syn_re),
      .rd_addr (syn_raddr),
      .rd_data (syn_rd)
   );

   bam_ram #(
      .WIDTH  (bam_pkg::WORD_W),
      .ADDR_W (bam_pkg::MASK_AW)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (mask_waddr),
      .wr_data (mask_wdata),
      .rd_en   (mask_re),
      .rd_addr (mask_raddr),
      .rd_data (mask_rd)
   );

   // An entry whose valid bit is clear holds the re-armed value, all ones.
   assign wr_slice   = bam_pkg::SLICE_W'(cnt_ff - bam_pkg::CNT_W'(1));
   assign cur_slice  = cnt_ff[bam_pkg::SLICE_W-1:0];
   assign mask_waddr = {cmd_ff.bin, wr_slice};
   assign out_addr   = {cmd_ff.bin, cur_slice};
   assign wr_cur     = valid_ff[mask_waddr] ? mask_rd : bam_pkg::ALL_ONES;
   assign out_cur    = valid_ff[out_addr] ? mask_rd : bam_pkg::ALL_ONES;
   assign mask_wdata = wr_cur & syn_rd;
   assign syn_waddr  = {head.row, head.widx};
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      start_in     = start_ff;
      slice_in     = slice_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      syn_we       = 1'b0;
      syn_re       = 1'b0;
      syn_raddr    = {head.row, bam_pkg::SLICE_W'(0)};
      mask_we      = 1'b0;
      mask_re      = 1'b0;
      mask_raddr   = {head.bin, bam_pkg::SLICE_W'(0)};

      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               unique case (head.op)
                  bam_pkg::OP_WRITE: begin
                     syn_we = 1'b1;
                  end
                  bam_pkg::OP_SPIKE: begin
                     syn_re   = 1'b1;
                     mask_re  = 1'b1;
                     cnt_in   = bam_pkg::CNT_W'(1);
                     state_in = B_SPIKE;
                  end
                  bam_pkg::OP_READ: begin
                     mask_re  = 1'b1;
                     cnt_in   = '0;
                     state_in = B_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_SPIKE: begin
            // Write back slice cnt-1 while reading slice cnt.
            mask_we              = 1'b1;
            valid_in[mask_waddr] = 1'b1;
            if (cnt_ff == bam_pkg::CNT_W'(bam_pkg::SLICES)) begin
               state_in = B_IDLE;
            end else begin
               syn_re     = 1'b1;
               mask_re    = 1'b1;
               syn_raddr  = {cmd_ff.row, cur_slice};
               mask_raddr = {cmd_ff.bin, cur_slice};
            end
            cnt_in = cnt_ff + bam_pkg::CNT_W'(1);
         end
         B_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               start_in     = cmd_ff.start;
               slice_in     = cur_slice;
               mask_in      = cmd_ff.present ? (out_cur & bam_pkg::live_bits(cur_slice)) : '0;
               last_in      = cur_slice == bam_pkg::SLICE_W'(bam_pkg::SLICES - 1);
               if (cmd_ff.present) begin
                  valid_in[out_addr] = 1'b0;
               end
               if (cur_slice == bam_pkg::SLICE_W'(bam_pkg::SLICES - 1)) begin
                  state_in = B_IDLE;
               end else begin
                  mask_re    = 1'b1;
                  mask_raddr = {cmd_ff.bin, bam_pkg::SLICE_W'(cur_slice + bam_pkg::SLICE_W'(1))};
                  cnt_in     = cnt_ff + bam_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      start_ff <= start_in;
      slice_ff <= slice_in;
      mask_ff  <= mask_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_start_time = start_ff;
   assign rsp_slice_index    = slice_ff;
   assign rsp_fired_mask     = mask_ff;
   assign rsp_last           = last_ff;

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bam_pkg::*;

   // Request type 3 has no meaning; the block must swallow such beats without a result.
   localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);

   // After the last expected result, a spike may still be working its way through the
   // divider and the mask read-modify-write, so the interval is only changed after this
   // many quiet cycles on top of an empty expectation queue.
   localparam int QUIET_CYCLES = 24;

   // The watchdog gives up after this many cycles without a single accepted beat on any
   // port. The longest legitimate silence is a long receiver stall or a settling pause,
   // so this leaves a wide margin, including any clearing after reset.
   localparam int IDLE_LIMIT = 3000;

   // One beat of the request channel, every field at the width of its port.
   typedef struct {
      logic [REQ_W-1:0]    kind;
      logic [ROW_IN_W-1:0] row;
      logic [WIDX_W-1:0]   slice;
      logic [WORD_W-1:0]   word;
      logic [TIME_W-1:0]   stamp;
      logic [BIDX_W-1:0]   bin;
   } request_t;

   // One beat of a readout as the block should present it.
   typedef struct {
      logic [TIME_W-1:0]  start;
      logic [SLICE_W-1:0] slice;
      logic [WORD_W-1:0]  mask;
      logic               last;
   } readout_beat_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type = REQ_WRITE;
   logic [ROW_IN_W-1:0] req_neuron_row = '0;
   logic [WIDX_W-1:0]   req_word_index = '0;
   logic [WORD_W-1:0]   req_matrix_word = '0;
   logic [TIME_W-1:0]   req_spike_time = '0;
   logic [BIDX_W-1:0]   req_bin_index = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TIME_W-1:0]   rsp_bin_start_time;
   logic [SLICE_W-1:0]  rsp_slice_index;
   logic [WORD_W-1:0]   rsp_fired_mask;
   logic                rsp_last;

   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   // Our own view of the block: the synapse matrix, which words of it have been written,
   // the fired mask of every bin and the current bin width.
   logic [WORD_W-1:0]   synapse_words  [INPUT_NEURONS*SLICES];
   bit                  word_written   [INPUT_NEURONS*SLICES];
   bit                  row_ready      [INPUT_NEURONS];
   int                  ready_rows     [$];
   logic [WORD_W-1:0]   bin_fire_masks [BINS*SLICES];
   logic [CFG_W-1:0]    interval_setting = CFG_RESET;

   readout_beat_t       expected_beats [$];
   readout_beat_t       head_beat;

   int                  fail_count = 0;
   int                  beats_sent = 0;
   int                  beats_checked = 0;
   int                  readouts_sent = 0;
   int                  settings_used = 1;
   int                  burst_left = 0;
   int                  idle_cycles = 0;

   int                  stall_mode = 0;
   int                  mode_timer = 0;
   int                  run_left = 0;

   binary_assoc_memory_spike_recall_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_neuron_row     (req_neuron_row),
      .req_word_index     (req_word_index),
      .req_matrix_word    (req_matrix_word),
      .req_spike_time     (req_spike_time),
      .req_bin_index      (req_bin_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bin_start_time (rsp_bin_start_time),
      .rsp_slice_index    (rsp_slice_index),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------------------

   // Output neurons that exist within one 64-neuron slice; the others never fire.
   function automatic logic [WORD_W-1:0] neuron_live_mask(int slice);
      int first_neuron;
      int count;
      first_neuron = slice * WORD_W;
      if (first_neuron >= OUTPUT_NEURONS) return '0;
      count = OUTPUT_NEURONS - first_neuron;
      if (count >= WORD_W) return '1;
      return (WORD_W'(1) << count) - WORD_W'(1);
   endfunction

   // Updates the matrix and the bin masks for one accepted request beat, and queues the
   // four readout beats that a readout request must produce.
   task automatic apply_request(input request_t r);
      int unsigned   bin_no;
      int unsigned   product;
      int            base;
      readout_beat_t beat;
      if (r.kind == REQ_WRITE) begin
         if (r.row < INPUT_NEURONS) begin
            base = int'(r.row) * SLICES;
            synapse_words[base + r.slice] = r.word;
            word_written[base + r.slice] = 1'b1;
            if (!row_ready[r.row] && word_written[base] && word_written[base + 1]
                && word_written[base + 2] && word_written[base + 3]) begin
               row_ready[r.row] = 1'b1;
               ready_rows.push_back(int'(r.row));
            end
         end
      end else if (r.kind == REQ_SPIKE) begin
         // A spike is dropped for an unknown row, a zero interval or a bin past the end.
         if (r.row < INPUT_NEURONS && interval_setting != 0) begin
            bin_no = r.stamp / interval_setting;
            if (bin_no < BINS) begin
               for (int k = 0; k < SLICES; k++) begin
                  bin_fire_masks[bin_no*SLICES + k] &= synapse_words[int'(r.row)*SLICES + k];
               end
            end
         end
      end else if (r.kind == REQ_READ) begin
         product = r.bin * interval_setting;
         readouts_sent++;
         for (int k = 0; k < SLICES; k++) begin
            beat.start = product[TIME_W-1:0];
            beat.slice = SLICE_W'(k);
            beat.last  = (k == SLICES - 1);
            beat.mask  = '0;
            // An absent bin reads as nothing fired and leaves every mask alone.
            if (r.bin < BINS) begin
               beat.mask = bin_fire_masks[r.bin*SLICES + k] & neuron_live_mask(k);
               bin_fire_masks[r.bin*SLICES + k] = ALL_ONES;
            end
            expected_beats.push_back(beat);
         end
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------------------

   // Every field starts random, so that the bits a request type does not use still toggle
   // and the block is seen to ignore them.
   function automatic request_t random_request(logic [REQ_W-1:0] kind);
      request_t r;
      r.kind  = kind;
      r.row   = ROW_IN_W'($urandom);
      r.slice = WIDX_W'($urandom);
      r.word  = {$urandom, $urandom};
      r.stamp = TIME_W'($urandom);
      r.bin   = BIDX_W'($urandom);
      return r;
   endfunction

   // Synapse words are mostly dense, so that a bin keeps some firing neurons after
   // several spikes; all ones and all zeros turn up as well.
   function automatic logic [WORD_W-1:0] random_synapse_word();
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return ALL_ONES;
         1:       return '0;
         2, 3:    return a | b | c;
         4:       return a | b;
         default: return a;
      endcase
   endfunction

   // A time stamp that lands in the given bin under the current interval.
   function automatic logic [TIME_W-1:0] stamp_in_bin(int bin_no);
      int unsigned stamp;
      if (interval_setting == 0) return TIME_W'($urandom);
      stamp = bin_no * interval_setting + $urandom_range(0, interval_setting - 1);
      return stamp[TIME_W-1:0];
   endfunction

   // Sends one beat. The sender works in bursts: when a burst is used up, valid drops for
   // a random gap and a fresh burst length is drawn. Within a burst valid stays high and
   // only the payload moves on, so valid never gets two assignments in one time step.
   task automatic send_request(input request_t r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_type        <= r.kind;
      req_neuron_row  <= r.row;
      req_word_index  <= r.slice;
      req_matrix_word <= r.word;
      req_spike_time  <= r.stamp;
      req_bin_index   <= r.bin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(r);
      beats_sent++;
   endtask

   task automatic send_write(input int row, input int slice, input logic [WORD_W-1:0] word);
      request_t r;
      r = random_request(REQ_WRITE);
      r.row   = ROW_IN_W'(row);
      r.slice = WIDX_W'(slice);
      r.word  = word;
      send_request(r);
   endtask

   task automatic send_spike(input int row, input logic [TIME_W-1:0] stamp);
      request_t r;
      r = random_request(REQ_SPIKE);
      r.row   = ROW_IN_W'(row);
      r.stamp = stamp;
      send_request(r);
   endtask

   task automatic send_readout(input int bin_no);
      request_t r;
      r = random_request(REQ_READ);
      r.bin = BIDX_W'(bin_no);
      send_request(r);
   endtask

   function automatic int pick_ready_row();
      return ready_rows[$urandom_range(0, ready_rows.size() - 1)];
   endfunction

   // Holds the sender back until every expected beat has arrived, then lets the block
   // finish any spike that is still in flight.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // The interval is only ever changed with the block idle.
   task automatic set_bin_width(input logic [CFG_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      interval_setting = value;
      settings_used++;
   endtask

   // ------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------

   // Hand-picked beats at the reset interval of 100: an empty bin, the AND of two rows,
   // re-arming after a readout, late spikes on and beyond the last bin, the unused
   // request type, and a rewritten matrix word.
   task automatic test_special_cases();
      for (int k = 0; k < SLICES; k++) send_write(0, k, ALL_ONES);
      send_write(255, 0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_write(255, 1, 64'h5555_5555_5555_5555);
      send_write(255, 2, '0);
      send_write(255, 3, 64'h8000_0000_0000_0001);
      send_readout(0);
      send_spike(0, 16'd0);
      send_spike(255, 16'd99);
      send_readout(0);
      send_readout(0);
      send_spike(255, 16'hFFFF);
      send_spike(255, 16'd1600);
      send_spike(255, 16'd1599);
      send_readout(BINS - 1);
      send_request(random_request(REQ_UNUSED));
      send_write(255, 2, ALL_ONES);
      send_spike(255, 16'd1500);
      send_readout(BINS - 1);
      send_readout(BINS - 1);
   endtask

   // Fills sixteen rows spread over the whole row range, so that later spikes only ever
   // read synapse words that have been written.
   task automatic test_matrix_load();
      for (int i = 0; i < 16; i++) begin
         for (int k = 0; k < SLICES; k++) send_write(i * 17, k, random_synapse_word());
      end
   endtask

   // Mostly well-formed recalls (a few spikes into one bin, then its readout), mixed with
   // matrix rewrites, stray spikes with any time stamp, stray readouts, the unused request
   // type, and now and then a pause until every result is back.
   task automatic test_recall_traffic(input int count);
      int target;
      int bin_no;
      int choice;
      target = beats_sent + count;
      while (beats_sent < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 62) begin
            bin_no = $urandom_range(0, BINS - 1);
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 5) == 0)
                  send_write(pick_ready_row(), $urandom_range(0, 3), random_synapse_word());
               send_spike(pick_ready_row(), stamp_in_bin(bin_no));
            end
            send_readout(bin_no);
         end else if (choice < 74) begin
            send_write($urandom_range(0, 255), $urandom_range(0, 3), random_synapse_word());
         end else if (choice < 83) begin
            send_spike(pick_ready_row(), TIME_W'($urandom));
         end else if (choice < 91) begin
            send_readout($urandom_range(0, BINS - 1));
         end else if (choice < 95) begin
            send_request(random_request(REQ_UNUSED));
         end else begin
            wait_for_drain();
         end
      end
   endtask

   // The narrowest and widest bins the register can hold.
   task automatic test_interval_extremes();
      set_bin_width(CFG_W'(1));
      test_recall_traffic(70);
      set_bin_width({CFG_W{1'b1}});
      test_recall_traffic(90);
   endtask

   // With a zero interval every spike is dropped, so each readout returns what earlier spikes left in its bin.
   task automatic test_zero_interval();
      set_bin_width('0);
      test_recall_traffic(20);
   endtask

   task automatic test_random_interval();
      set_bin_width(CFG_W'($urandom_range(2, 4094)));
      test_recall_traffic(60);
   endtask

   // ------------------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------------------

   // The receiver stalls in modes that change at random: never, seldom, half the time,
   // or in long runs that keep results waiting.
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_timer <= $urandom_range(40, 240);
      end else begin
         mode_timer <= mode_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (run_left == 0) begin
               rsp_stall <= !rsp_stall;
               run_left  <= rsp_stall ? $urandom_range(0, 7) : $urandom_range(0, 39);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   task automatic check_field(input string name, input logic [WORD_W-1:0] expected,
                              input logic [WORD_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %h, got %h", name, expected, actual);
         fail_count++;
      end
   endtask

   // Every accepted result beat is held against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: start %h slice %0d mask %h last %b",
                   rsp_bin_start_time, rsp_slice_index, rsp_fired_mask, rsp_last);
            fail_count++;
         end else begin
            head_beat = expected_beats.pop_front();
            check_field("bin_start_time", WORD_W'(head_beat.start), WORD_W'(rsp_bin_start_time));
            check_field("slice_index", WORD_W'(head_beat.slice), WORD_W'(rsp_slice_index));
            check_field("fired_mask", head_beat.mask, rsp_fired_mask);
            check_field("last", WORD_W'(head_beat.last), WORD_W'(rsp_last));
         end
         beats_checked++;
      end
   end

   // Ends the run when no port has moved a beat for far longer than any correct run needs.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------------------

   initial begin
      for (int i = 0; i < INPUT_NEURONS*SLICES; i++) begin
         synapse_words[i] = '0;
         word_written[i]  = 1'b0;
      end
      for (int i = 0; i < INPUT_NEURONS; i++) row_ready[i] = 1'b0;
      for (int i = 0; i < BINS*SLICES; i++) bin_fire_masks[i] = ALL_ONES;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_matrix_load();
      test_recall_traffic(110);
      test_interval_extremes();
      test_zero_interval();
      test_random_interval();

      wait_for_drain();
      $display("Run covered %0d request beats, %0d readouts and %0d result beats",
               beats_sent, readouts_sent, beats_checked);
      $display("over %0d bin widths including 0, 1 and 4095", settings_used);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bam_pkg.sv
rtl/bam_ram.sv
rtl/bam_front.sv
rtl/bam_fifo.sv
rtl/bam_back.sv
rtl/binary_assoc_memory_spike_recall_core.sv
tb/testbench.sv
